>>> hdl/q16fir_pkg.sv
// Package for the Q16 FIR filter: word layouts, operation codes, controller states
// and the control bundle passed to the datapath. No dependencies.
`timescale 1ns / 1ps

package q16fir_pkg;

   localparam int SAMPLE_W      = 16;
   localparam int COEF_W        = 32;
   localparam int ACC_W         = 32;
   localparam int FRAC_BITS     = 16;
   localparam int ROUND_BIT     = FRAC_BITS - 1;
   localparam int COEF_INDEX_W  = 5;
   localparam int TAP_COUNT_W   = 6;

   localparam logic [TAP_COUNT_W-1:0]     TAP_COUNT_RESET = 6'd32;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX      = 16'sh7FFF;

   typedef enum logic [1:0] {
      OP_SAMPLE = 2'd0,
      OP_LOAD   = 2'd1,
      OP_FLUSH  = 2'd2
   } q16fir_op_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WRAP,
      ST_MAC,
      ST_DRAIN
   } q16fir_state_type;

   typedef struct packed {
      logic [1:0]                  op;
      logic signed [SAMPLE_W-1:0]  sample;
      logic [COEF_INDEX_W-1:0]     coef_index;
      logic signed [COEF_W-1:0]    coef_value;
   } q16fir_req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0]  filtered;
      logic                        saturated;
   } q16fir_rsp_type;

   typedef struct packed {
      logic ring_we;
      logic coef_we;
      logic mac_en;
      logic acc_clear;
   } q16fir_ctrl_type;

endpackage

>>> hdl/q16fir_datapath.sv
// Sample ring and coefficient memories with the multiply-accumulate pipeline.
// Depends on q16fir_pkg.
`timescale 1ns / 1ps

module q16fir_datapath
   import q16fir_pkg::*;
#(
   parameter int MAX_TAPS = 32,
   parameter int AddrW    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1
) (
   input  logic                       clock,
   input  logic                       reset,
   input  q16fir_ctrl_type            ctrl,
   input  logic [AddrW-1:0]           ring_waddr,
   input  logic signed [SAMPLE_W-1:0] ring_wdata,
   input  logic [AddrW-1:0]           ring_raddr,
   input  logic [AddrW-1:0]           coef_waddr,
   input  logic signed [COEF_W-1:0]   coef_wdata,
   input  logic [AddrW-1:0]           coef_raddr,
   output logic [ACC_W-1:0]           acc,
   output logic                       busy
);

   logic signed [SAMPLE_W-1:0] ring_mem [MAX_TAPS];
   logic signed [COEF_W-1:0]   coef_mem [MAX_TAPS];

   logic signed [SAMPLE_W-1:0] ring_rd_ff;
   logic signed [COEF_W-1:0]   coef_rd_ff;
   logic                       rd_vld_ff;
   logic [ACC_W-1:0]           prod_ff;
   logic                       prod_vld_ff;
   logic [ACC_W-1:0]           acc_ff;
   logic signed [SAMPLE_W+COEF_W-1:0] prod_full;

   // Both memories: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (ctrl.ring_we) begin
         ring_mem[ring_waddr] <= ring_wdata;
      end
      ring_rd_ff <= ring_mem[ring_raddr];
   end

   always_ff @(posedge clock) begin
      if (ctrl.coef_we) begin
         coef_mem[coef_waddr] <= coef_wdata;
      end
      coef_rd_ff <= coef_mem[coef_raddr];
   end

   // Only the low 32 bits of the product matter, as the sum wraps.
   assign prod_full = ring_rd_ff * coef_rd_ff;

   always_ff @(posedge clock) begin
      prod_ff <= prod_full[ACC_W-1:0];
      if (ctrl.acc_clear) begin
         acc_ff <= '0;
      end else if (prod_vld_ff) begin
         acc_ff <= acc_ff + prod_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff   <= 1'b0;
         prod_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff   <= ctrl.mac_en;
         prod_vld_ff <= rd_vld_ff;
      end
   end

   assign acc  = acc_ff;
   assign busy = rd_vld_ff | prod_vld_ff;

endmodule

>>> hdl/q16fir_filter_int16_top.sv
// Top level of the Q16 FIR filter: controller state machine, configuration register
// and result register. Depends on q16fir_pkg and q16fir_datapath.
`timescale 1ns / 1ps

// The filter takes one word at a time on the req channel. A sample word (op 0) moves the
// ring position on by one, modulo the tap count, stores the sample there and then runs
// a single multiply-accumulate unit over the taps, newest sample first, reading one
// entry of the sample memory and one of the coefficient memory per cycle. A sample word
// therefore passes through acceptance, then the wrap of the position, which subtracts
// the tap count from the advanced position one subtraction at a time (once each time the
// position comes back round to zero, and more often when the tap count was lowered
// without a flush), then one multiply-accumulate per tap, and last the drain of the
// memory read, product and accumulator registers. The result word is then held in an
// output register, so the next word is taken while the result still waits. A load word
// (op 1) writes one coefficient in the cycle it is accepted and returns nothing; an
// index of MAX_TAPS or above is ignored. A flush word (op 2) zeroes the position and
// sweeps the whole sample memory, one entry a cycle, accepting no word meanwhile; the
// same sweep runs after reset. Op 3 is accepted and ignored. A coefficient must be loaded
// before any sample uses it. The tap_count register is written through the csr channel,
// which is always ready, and should only be written while the filter is idle, followed
// by a flush. A tap count of zero acts as one and values above MAX_TAPS act as MAX_TAPS.
// The sum wraps at 32 bits; the result is the sum shifted right by 16 and rounded half
// up, and saturated is set when that rounding would pass the largest int16 value.

module q16_fir_filter_int16_top
   import q16fir_pkg::*;
#(
   parameter int MAX_TAPS = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  q16fir_req_type         req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output q16fir_rsp_type         rsp_word,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [TAP_COUNT_W-1:0] csr_word
);

   localparam int AddrW    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
   localparam int ModW     = AddrW + 1;
   localparam int LenW     = $clog2(MAX_TAPS + 1);
   localparam int CntExtW  = LenW + TAP_COUNT_W;
   localparam int IdxExtW  = AddrW + COEF_INDEX_W;

   q16fir_state_type state_ff, state_in;

   logic [TAP_COUNT_W-1:0] tap_count_ff;
   logic [AddrW-1:0]       wp_ff, wp_in;
   logic [ModW-1:0]        mod_ff, mod_in;
   logic [AddrW-1:0]       pos_ff, pos_in;
   logic [AddrW-1:0]       tap_ff, tap_in;
   logic [AddrW-1:0]       clr_ff, clr_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] sample_ff;
   q16fir_rsp_type         rsp_word_ff;
   q16fir_rsp_type         rsp_next;
   logic                   rsp_load;

   logic [LenW-1:0]        len;
   logic [ModW-1:0]        len_ext;
   logic [AddrW-1:0]       last_tap;
   logic [CntExtW-1:0]     cnt_ext;
   logic [IdxExtW-1:0]     idx_ext;
   logic                   req_fire;

   q16fir_ctrl_type             ctrl;
   logic [AddrW-1:0]            ring_waddr;
   logic signed [SAMPLE_W-1:0]  ring_wdata;
   logic [ACC_W-1:0]            acc;
   logic                        dp_busy;

   logic [SAMPLE_W-1:0]         acc_upper;
   logic                        acc_round;

   // Number of taps in use, clamped into 1..MAX_TAPS.
   always_comb begin
      cnt_ext = CntExtW'(tap_count_ff);
      if (tap_count_ff == '0) begin
         len = LenW'(1);
      end else if (cnt_ext > CntExtW'(MAX_TAPS)) begin
         len = LenW'(MAX_TAPS);
      end else begin
         len = cnt_ext[LenW-1:0];
      end
   end

   assign len_ext  = ModW'(len);
   assign last_tap = AddrW'(len - LenW'(1));
   assign idx_ext  = IdxExtW'(req_word.coef_index);

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid & req_ready;
   assign csr_ready = 1'b1;

   // Round half up on the Q16 sum; only a rounded value of 32768 needs clipping.
   assign acc_upper = acc[ACC_W-1:FRAC_BITS];
   assign acc_round = acc[ROUND_BIT];

   always_comb begin
      if ((acc_upper == SAMPLE_MAX) && acc_round) begin
         rsp_next.filtered  = SAMPLE_MAX;
         rsp_next.saturated = 1'b1;
      end else begin
         rsp_next.filtered  = acc_upper + SAMPLE_W'(acc_round);
         rsp_next.saturated = 1'b0;
      end
   end

   // Controller: next state, counters and datapath controls.
   always_comb begin
      state_in       = state_ff;
      wp_in          = wp_ff;
      mod_in         = mod_ff;
      pos_in         = pos_ff;
      tap_in         = tap_ff;
      clr_in         = clr_ff;
      rsp_load       = 1'b0;
      ctrl.ring_we   = 1'b0;
      ctrl.coef_we   = 1'b0;
      ctrl.mac_en    = 1'b0;
      ctrl.acc_clear = 1'b0;
      ring_waddr     = mod_ff[AddrW-1:0];
      ring_wdata     = sample_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            ctrl.ring_we = 1'b1;
            ring_waddr   = clr_ff;
            ring_wdata   = '0;
            clr_in       = clr_ff + AddrW'(1);
            if (clr_ff == AddrW'(MAX_TAPS - 1)) begin
               clr_in   = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               case (req_word.op)
                  OP_SAMPLE: begin
                     mod_in   = ModW'(wp_ff) + ModW'(1);
                     state_in = ST_WRAP;
                  end
                  OP_LOAD: begin
                     ctrl.coef_we = (idx_ext < IdxExtW'(MAX_TAPS));
                  end
                  OP_FLUSH: begin
                     wp_in    = '0;
                     clr_in   = '0;
                     state_in = ST_CLEAR;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_WRAP: begin
            // Reduce the advanced position modulo the tap count, one subtraction a cycle.
            if (mod_ff >= len_ext) begin
               mod_in = mod_ff - len_ext;
            end else begin
               ctrl.ring_we   = 1'b1;
               ctrl.acc_clear = 1'b1;
               wp_in          = mod_ff[AddrW-1:0];
               pos_in         = mod_ff[AddrW-1:0];
               tap_in         = '0;
               state_in       = ST_MAC;
            end
         end
         ST_MAC: begin
            ctrl.mac_en = 1'b1;
            pos_in      = (pos_ff == '0) ? last_tap : (pos_ff - AddrW'(1));
            tap_in      = tap_ff + AddrW'(1);
            if (tap_ff == last_tap) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!dp_busy && (!rsp_valid_ff || rsp_ready)) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         wp_ff        <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         tap_count_ff <= TAP_COUNT_RESET;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            tap_count_ff <= csr_word;
         end
      end
   end

   always_ff @(posedge clock) begin
      mod_ff <= mod_in;
      pos_ff <= pos_in;
      tap_ff <= tap_in;
      if (req_fire) begin
         sample_ff <= req_word.sample;
      end
      if (rsp_load) begin
         rsp_word_ff <= rsp_next;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   q16fir_datapath #(
      .MAX_TAPS (MAX_TAPS),
      .AddrW    (AddrW)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .ring_waddr (ring_waddr),
      .ring_wdata (ring_wdata),
      .ring_raddr (pos_ff),
      .coef_waddr (idx_ext[AddrW-1:0]),
      .coef_wdata (req_word.coef_value),
      .coef_raddr (tap_ff),
      .acc        (acc),
      .busy       (dp_busy)
   );

   // The read position and tap number stay inside the taps in use while accumulating.
   a_mac_tap_range : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MAC) |-> ((LenW + 1)'(tap_ff) < (LenW + 1)'(len)))
      else $error("tap number outside the taps in use");

   a_mac_pos_range : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MAC) |-> ((LenW + 1)'(pos_ff) < (LenW + 1)'(len)))
      else $error("ring read position outside the taps in use");

   // A new word is only taken once the accumulation pipeline has emptied.
   a_idle_pipe_empty : assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !dp_busy)
      else $error("word accepted while the accumulator pipeline is busy");

   // A result only appears at the end of a drained accumulation.
   a_rsp_from_drain : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_DRAIN))
      else $error("result raised outside the drain step");

endmodule

>>> bench/tb.sv
// Self-checking bench for the Q16 FIR filter: drives sample, load and flush words, predicts
// every filtered result and compares it with what the filter returns.
// Depends on q16fir_pkg and q16_fir_filter_int16_top.
`timescale 1ns / 1ps

module tb;
   import q16fir_pkg::*;

   localparam int MAX_TAPS = 32;

   // Op 3 has no name in the package. The filter accepts it and does nothing.
   localparam logic [1:0] OP_IGNORED = 2'd3;

   // Cycles to let pass once the last result is in. This covers a flush sweep, or a sample
   // at full length after a lowered tap count, with margin.
   localparam int BLOCK_LATENCY = 2 * MAX_TAPS + 40;

   // Length of the deliberate receiver stall, and the watchdog limit. The limit is several
   // times the longest quiet stretch that a correct run can show.
   localparam int HOLD_CYCLES = 400;
   localparam int STALL_LIMIT = 4000;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   q16fir_req_type         req_word;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   q16fir_rsp_type         rsp_word;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [TAP_COUNT_W-1:0] csr_word;

   q16_fir_filter_int16_top #(
      .MAX_TAPS(MAX_TAPS)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_word (req_word),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_word (rsp_word),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_word (csr_word)
   );

   // Words waiting to be offered, and the results that the accepted words should produce.
   q16fir_req_type word_backlog[$];
   q16fir_rsp_type filter_outputs[$];

   // The bench's own copy of the filter state. The coefficient table starts as zero only
   // for tidiness: the stimulus never lets a sample read an entry that was never loaded.
   logic [SAMPLE_W-1:0]    ring_mem[MAX_TAPS];
   logic [COEF_W-1:0]      coef_mem[MAX_TAPS];
   int                     ring_head;
   logic [TAP_COUNT_W-1:0] tap_reg;

   // Which coefficients the queued stimulus has loaded so far, in queue order.
   bit                     gen_loaded[MAX_TAPS];

   // Idle rates in percent, set per phase by the stimulus process.
   int                     tx_idle_pct;
   int                     rx_idle_pct;

   // The stimulus process arms the long receiver stall; the receiver process runs it once.
   bit                     pressure_arm;
   bit                     pressure_done;
   int                     hold_left;

   int                     errors;
   int                     stall_cycles;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // A tap count of zero behaves as one, anything above the table size as the full table.
   function automatic int effective_taps(input logic [TAP_COUNT_W-1:0] count);
      if (count == 0) begin
         return 1;
      end
      if (count > MAX_TAPS) begin
         return MAX_TAPS;
      end
      return int'(count);
   endfunction

   // Applies one accepted word to the bench's state. A sample word also works out the
   // filtered result that it should produce and queues it.
   task automatic predict_filtered(input q16fir_req_type w);
      int                  len;
      int                  pos;
      logic [ACC_W-1:0]    acc;
      logic [ACC_W-1:0]    wide_sample;
      logic [SAMPLE_W-1:0] upper;
      q16fir_rsp_type      out;
      case (w.op)
         OP_LOAD: begin
            coef_mem[w.coef_index] = w.coef_value;
         end
         OP_FLUSH: begin
            foreach (ring_mem[i]) ring_mem[i] = '0;
            ring_head = 0;
         end
         OP_SAMPLE: begin
            len = effective_taps(tap_reg);
            // After a lowered tap count the old head may lie beyond the new length; the
            // step forward is still reduced modulo the new length.
            ring_head = (ring_head + 1) % len;
            ring_mem[ring_head] = w.sample;
            acc = '0;
            for (int i = 0; i < len; i++) begin
               pos = (ring_head >= i) ? ring_head - i : ring_head + len - i;
               wide_sample = {{(ACC_W - SAMPLE_W){ring_mem[pos][SAMPLE_W-1]}}, ring_mem[pos]};
               acc = acc + wide_sample * coef_mem[i];
            end
            // Shift out the fraction and round half up. Only an upper half of 0x7FFF with
            // the rounding bit set can pass the int16 range, and it is clipped.
            upper = acc[ACC_W-1:FRAC_BITS];
            if (upper == SAMPLE_MAX && acc[ROUND_BIT]) begin
               out.filtered  = SAMPLE_MAX;
               out.saturated = 1'b1;
            end else begin
               out.filtered  = upper + acc[ROUND_BIT];
               out.saturated = 1'b0;
            end
            filter_outputs.push_back(out);
         end
         default: begin
         end
      endcase
   endtask

   // Sender. A new word is put up only once the previous one has gone, so valid and the
   // payload never change while a word waits for ready.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predict_filtered(req_word);
         end
         if (!req_valid || req_ready) begin
            if (word_backlog.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
               req_valid <= 1'b1;
               req_word  <= word_backlog.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver. Once armed it holds ready low for a long stretch, counted here, so that the
   // filter fills its output register and then refuses further input.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready     <= 1'b0;
         hold_left     <= 0;
         pressure_done <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (pressure_arm && !pressure_done) begin
         rsp_ready     <= 1'b0;
         hold_left     <= HOLD_CYCLES;
         pressure_done <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
   end

   // Checker. Every result word taken is compared with the oldest expectation.
   always @(posedge clock) begin
      q16fir_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (filter_outputs.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual filtered %0d saturated %0b",
                     $time, rsp_word.filtered, rsp_word.saturated);
            errors++;
         end else begin
            want = filter_outputs.pop_front();
            if (rsp_word.filtered !== want.filtered) begin
               $display("%0t: filtered mismatch, expected %0d, actual %0d",
                        $time, want.filtered, rsp_word.filtered);
               errors++;
            end
            if (rsp_word.saturated !== want.saturated) begin
               $display("%0t: saturated mismatch, expected %0b, actual %0b",
                        $time, want.saturated, rsp_word.saturated);
               errors++;
            end
         end
      end
   end

   // Watchdog. Counts cycles in which no handshake completes on any channel.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, stall_cycles);
         $display("TEST FAILED");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   function automatic logic [COEF_W-1:0] rand_coef();
      // Mostly coefficients of a realistic size around one in Q16, sometimes any value.
      if ($urandom_range(0, 9) < 4) begin
         return $urandom;
      end
      return $urandom_range(0, 32'h40000) - 32'h20000;
   endfunction

   task automatic queue_word(input logic [1:0] op, input logic [SAMPLE_W-1:0] sample,
                             input logic [COEF_INDEX_W-1:0] index,
                             input logic [COEF_W-1:0] value);
      q16fir_req_type w;
      w.op         = op;
      w.sample     = sample;
      w.coef_index = index;
      w.coef_value = value;
      if (op == OP_LOAD) begin
         gen_loaded[index] = 1'b1;
      end
      word_backlog.push_back(w);
   endtask

   // Random words for one phase. Before any sample, every coefficient that the current tap
   // count reaches is loaded if it has not been yet. Fields unused by an op stay random.
   task automatic queue_random(input int count, input int taps);
      int                  pick;
      logic [SAMPLE_W-1:0] sample;
      for (int k = 0; k < count; k++) begin
         pick = $urandom_range(0, 99);
         if (pick < 60) begin
            for (int i = 0; i < taps; i++) begin
               if (!gen_loaded[i]) begin
                  queue_word(OP_LOAD, SAMPLE_W'($urandom), COEF_INDEX_W'(i), rand_coef());
               end
            end
            case ($urandom_range(0, 9))
               0:       sample = 16'h7FFF;
               1:       sample = 16'h8000;
               2:       sample = $urandom_range(0, 1) ? 16'h0000 : 16'hFFFF;
               default: sample = SAMPLE_W'($urandom);
            endcase
            queue_word(OP_SAMPLE, sample, COEF_INDEX_W'($urandom), $urandom);
         end else if (pick < 85) begin
            queue_word(OP_LOAD, SAMPLE_W'($urandom), COEF_INDEX_W'($urandom), rand_coef());
         end else if (pick < 92) begin
            queue_word(OP_FLUSH, SAMPLE_W'($urandom), COEF_INDEX_W'($urandom), $urandom);
         end else begin
            queue_word(OP_IGNORED, SAMPLE_W'($urandom), COEF_INDEX_W'($urandom), $urandom);
         end
      end
   endtask

   // Waits until every word has gone in and every result has come out, then lets the
   // filter finish any flush sweep or calculation that produces no result.
   task automatic wait_idle();
      while (word_backlog.size() != 0 || req_valid || filter_outputs.size() != 0) begin
         @(posedge clock);
      end
      repeat (BLOCK_LATENCY) @(posedge clock);
   endtask

   task automatic write_tap_count(input logic [TAP_COUNT_W-1:0] count);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_word  <= count;
      do begin
         @(posedge clock);
      end while (!csr_ready);
      csr_valid <= 1'b0;
      tap_reg = count;
   endtask

   // One phase: a new tap count written while the filter is idle, an optional flush, then
   // random words. Leaving out the flush checks that old samples survive the change.
   task automatic run_phase(input logic [TAP_COUNT_W-1:0] count, input bit with_flush,
                            input int items);
      wait_idle();
      write_tap_count(count);
      if (with_flush) begin
         queue_word(OP_FLUSH, SAMPLE_W'($urandom), COEF_INDEX_W'($urandom), $urandom);
      end
      queue_random(items, effective_taps(count));
   endtask

   initial begin
      reset     = 1'b1;
      req_word  = '0;
      csr_valid = 1'b0;
      csr_word  = '0;
      errors    = 0;
      foreach (ring_mem[i]) ring_mem[i] = '0;
      foreach (coef_mem[i]) coef_mem[i] = '0;
      foreach (gen_loaded[i]) gen_loaded[i] = 1'b0;
      ring_head    = 0;
      tap_reg      = TAP_COUNT_RESET;
      pressure_arm = 1'b0;
      tx_idle_pct  = 7;
      rx_idle_pct  = 66;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed words on four taps. The wait covers the clearing sweep after reset.
      wait_idle();
      write_tap_count(6'd4);
      queue_word(OP_LOAD, 16'h0000, 5'd0, 32'h7FFF8000);
      queue_word(OP_LOAD, 16'h0000, 5'd1, 32'h80000000);
      queue_word(OP_LOAD, 16'h0000, 5'd2, 32'h7FFFFFFF);
      queue_word(OP_LOAD, 16'h0000, 5'd3, 32'h00010000);
      // With a cleared history this rounds up to 32768, which must clip.
      queue_word(OP_SAMPLE, 16'h0001, 5'd0, 32'h0);
      queue_word(OP_FLUSH, 16'h0000, 5'd0, 32'h0);
      queue_word(OP_SAMPLE, 16'h7FFF, 5'd0, 32'h0);
      queue_word(OP_SAMPLE, 16'h8000, 5'd0, 32'h0);
      queue_word(OP_SAMPLE, 16'hFFFF, 5'd0, 32'h0);
      queue_word(OP_IGNORED, 16'hFFFF, 5'd31, 32'hFFFFFFFF);
      // Stored beyond the tap count, so not used until the count grows.
      queue_word(OP_LOAD, 16'hFFFF, 5'd31, 32'hFFFFFFFF);
      queue_word(OP_SAMPLE, 16'h0000, 5'd31, 32'hFFFFFFFF);
      queue_word(OP_SAMPLE, 16'h8000, 5'd0, 32'h0);
      // One half times one, from a clean history, rounds up to one.
      queue_word(OP_FLUSH, 16'hFFFF, 5'd31, 32'hFFFFFFFF);
      queue_word(OP_LOAD, 16'h0000, 5'd0, 32'h00008000);
      queue_word(OP_SAMPLE, 16'h0001, 5'd0, 32'h0);
      // Minus one half rounds up to zero.
      queue_word(OP_FLUSH, 16'h0000, 5'd0, 32'h0);
      queue_word(OP_LOAD, 16'h0000, 5'd0, 32'hFFFF8000);
      queue_word(OP_SAMPLE, 16'h0001, 5'd0, 32'h0);
      queue_word(OP_SAMPLE, 16'h7FFF, 5'd0, 32'h0);
      queue_word(OP_SAMPLE, 16'h8000, 5'd0, 32'h0);

      // Random phases. The tap count is lowered without a flush first, so the position
      // wraps from beyond the new length and the old samples stay in use.
      run_phase(6'd2, 1'b0, 100);
      run_phase(6'd32, 1'b1, 100);
      pressure_arm = 1'b1;

      tx_idle_pct = 66;
      rx_idle_pct = 7;
      run_phase(6'd0, 1'b1, 100);
      run_phase(6'd63, 1'b0, 100);

      tx_idle_pct = 0;
      rx_idle_pct = 0;
      run_phase(TAP_COUNT_W'($urandom_range(1, MAX_TAPS)), 1'b1, 100);
      run_phase(6'd1, 1'b1, 100);

      wait_idle();
      if (errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

>>> filelist.f
hdl/q16fir_pkg.sv
hdl/q16fir_datapath.sv
hdl/q16fir_filter_int16_top.sv
bench/tb.sv
